// File: hdl/mpev_pkg.sv
`default_nettype none
package mpev_pkg;

   localparam int QW       = 32;
   localparam int FRAC     = 16;
   localparam int PROD_W   = 2 * QW - FRAC;
   localparam int ACC_W    = PROD_W + 6;
   localparam int NDIM     = 4;
   localparam int NOUT     = 4;
   localparam int NTERM    = 64;
   localparam int MAX_DEG  = 7;
   localparam int EXP_W    = 3;
   localparam int DIM_W    = 2;
   localparam int OUT_W    = 2;
   localparam int TERM_W   = 6;

   localparam logic [1:0] CSR_TERMS = 2'd0;
   localparam logic [1:0] CSR_OUTS  = 2'd1;
   localparam logic [1:0] CSR_DIMS  = 2'd2;

   localparam logic signed [QW-1:0] Q_ONE = QW'(1) <<< FRAC;

   typedef enum logic [1:0] {
      FUNC_LOAD_EXP  = 2'd0,
      FUNC_LOAD_COEF = 2'd1,
      FUNC_EVAL      = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_POW,
      ST_DINIT,
      ST_CHAIN,
      ST_COEF,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             clear;
      logic             load;
      logic             pow_step;
      logic [EXP_W-1:0] pow_k;
      logic             dinit;
      logic             chain_step;
      logic [DIM_W-1:0] chain_dim;
      logic             mul_en;
      logic             acc_en;
      logic [OUT_W-1:0] acc_sel;
      logic [OUT_W-1:0] rd_sel;
   } ctl_type;

   typedef struct packed {
      logic                       sat;
      logic signed [QW-1:0]       val;
   } qres_type;

   typedef struct packed {
      logic                       sat;
      logic [NDIM-1:0][QW-1:0]    grad;
      logic [QW-1:0]              value;
   } res_type;

   function automatic qres_type sat_wide(input logic signed [ACC_W-1:0] v);
      qres_type r;
      r.sat = 1'b0;
      r.val = v[QW-1:0];
      if (!(v[ACC_W-1:QW-1] == '0 || v[ACC_W-1:QW-1] == '1)) begin
         r.sat = 1'b1;
         r.val = v[ACC_W-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end
      return r;
   endfunction

   // round half up, floor shift
   function automatic logic signed [PROD_W-1:0] rnd(input logic signed [2*QW-1:0] p);
      logic signed [2*QW-1:0] w;
      w = p + (2*QW)'(64'sd1 <<< (FRAC - 1));
      return w[2*QW-1:FRAC];
   endfunction

   function automatic qres_type qmul(input logic signed [QW-1:0] a,
                                     input logic signed [QW-1:0] b);
      logic signed [2*QW-1:0] p;
      p = a * b;
      return sat_wide(ACC_W'(rnd(p)));
   endfunction

endpackage
`default_nettype wire

// File: hdl/mpev_ram.sv
`default_nettype none
module mpev_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/mpev_lane.sv
`default_nettype none
module mpev_lane #(
   parameter int LANE = 0
) (
   input  wire logic                                 clock,
   input  wire mpev_pkg::ctl_type                    ctl,
   input  wire logic signed [mpev_pkg::QW-1:0]       x,
   input  wire logic        [mpev_pkg::EXP_W-1:0]    e_in,
   input  wire logic signed [mpev_pkg::QW-1:0]       pow_sel,
   input  wire logic signed [mpev_pkg::QW-1:0]       coeff,
   output logic signed      [mpev_pkg::QW-1:0]       pow_out,
   output logic signed      [mpev_pkg::ACC_W-1:0]    acc_out,
   output logic                                      sat_out
);

   logic        [mpev_pkg::EXP_W-1:0]  e_ff;
   logic signed [mpev_pkg::QW-1:0]     r_ff;
   logic signed [mpev_pkg::QW-1:0]     pm1_ff;
   logic signed [mpev_pkg::QW-1:0]     t_ff;
   logic signed [mpev_pkg::PROD_W-1:0] prod_ff;
   logic signed [mpev_pkg::ACC_W-1:0]  acc_ff [mpev_pkg::NOUT];
   logic                               sat_ff;

   mpev_pkg::qres_type q_pow;
   mpev_pkg::qres_type q_chain;
   mpev_pkg::qres_type q_der;
   logic signed [mpev_pkg::QW+mpev_pkg::EXP_W:0] der_w;
   logic signed [2*mpev_pkg::QW-1:0]              cprod;

   always_comb begin
      q_pow   = mpev_pkg::qmul(r_ff, x);
      q_chain = mpev_pkg::qmul(t_ff, pow_sel);
      der_w   = $signed({1'b0, e_ff}) * pm1_ff;
      q_der   = mpev_pkg::sat_wide(mpev_pkg::ACC_W'(der_w));
      cprod   = coeff * t_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         for (int i = 0; i < mpev_pkg::NOUT; i++) begin
            acc_ff[i] <= '0;
         end
         sat_ff <= 1'b0;
      end
      if (ctl.load) begin
         e_ff <= e_in;
         r_ff <= mpev_pkg::Q_ONE;
      end
      if (ctl.pow_step && ctl.pow_k < e_ff) begin
         pm1_ff <= r_ff;
         r_ff   <= q_pow.val;
         if (q_pow.sat) begin
            sat_ff <= 1'b1;
         end
      end
      if (ctl.dinit && e_ff != '0) begin
         t_ff <= q_der.val;
         if (q_der.sat) begin
            sat_ff <= 1'b1;
         end
      end
      if (ctl.chain_step && e_ff != '0 && ctl.chain_dim != mpev_pkg::DIM_W'(LANE)) begin
         t_ff <= q_chain.val;
         if (q_chain.sat) begin
            sat_ff <= 1'b1;
         end
      end
      if (ctl.mul_en) begin
         prod_ff <= mpev_pkg::rnd(cprod);
      end
      if (ctl.acc_en && e_ff != '0) begin
         acc_ff[ctl.acc_sel] <= acc_ff[ctl.acc_sel] + mpev_pkg::ACC_W'(prod_ff);
      end
   end

   assign pow_out = r_ff;
   assign acc_out = acc_ff[ctl.rd_sel];
   assign sat_out = sat_ff;

endmodule
`default_nettype wire

// File: hdl/mpev_merge.sv
`default_nettype none
module mpev_merge (
   input  wire logic                                 clock,
   input  wire mpev_pkg::ctl_type                    ctl,
   input  wire logic signed [mpev_pkg::QW-1:0]       pow_sel,
   input  wire logic signed [mpev_pkg::QW-1:0]       coeff,
   input  wire logic signed [mpev_pkg::ACC_W-1:0]    lane_acc [mpev_pkg::NDIM],
   input  wire logic        [mpev_pkg::NDIM-1:0]     lane_sat,
   output mpev_pkg::res_type                         res
);

   logic signed [mpev_pkg::QW-1:0]     mono_ff;
   logic signed [mpev_pkg::PROD_W-1:0] mprod_ff;
   logic signed [mpev_pkg::ACC_W-1:0]  vacc_ff [mpev_pkg::NOUT];
   logic                               msat_ff;

   mpev_pkg::qres_type               q_mono;
   mpev_pkg::qres_type               q_val;
   mpev_pkg::qres_type               q_g [mpev_pkg::NDIM];
   logic signed [2*mpev_pkg::QW-1:0] cprod;

   always_comb begin
      q_mono = mpev_pkg::qmul(mono_ff, pow_sel);
      cprod  = coeff * mono_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         for (int i = 0; i < mpev_pkg::NOUT; i++) begin
            vacc_ff[i] <= '0;
         end
         msat_ff <= 1'b0;
      end
      if (ctl.load) begin
         mono_ff <= mpev_pkg::Q_ONE;
      end
      if (ctl.chain_step) begin
         mono_ff <= q_mono.val;
         if (q_mono.sat) begin
            msat_ff <= 1'b1;
         end
      end
      if (ctl.mul_en) begin
         mprod_ff <= mpev_pkg::rnd(cprod);
      end
      if (ctl.acc_en) begin
         vacc_ff[ctl.acc_sel] <= vacc_ff[ctl.acc_sel] + mpev_pkg::ACC_W'(mprod_ff);
      end
   end

   // final clip of the sums for the result being sent
   always_comb begin
      q_val     = mpev_pkg::sat_wide(vacc_ff[ctl.rd_sel]);
      res.value = q_val.val;
      res.sat   = msat_ff | q_val.sat | (|lane_sat);
      for (int j = 0; j < mpev_pkg::NDIM; j++) begin
         q_g[j]      = mpev_pkg::sat_wide(lane_acc[j]);
         res.grad[j] = q_g[j].val;
         res.sat     = res.sat | q_g[j].sat;
      end
   end

endmodule
`default_nettype wire

// File: hdl/multivariate_polynomial_eval_grad.sv
// Sequence: an evaluate item works through its nt terms in turn, then emits its results
//   (nt terms, no outputs in use); per term: fetch, load, seven power steps, derivative set-up,
//   four chain steps, one coefficient read per output and a drain of the multiply-accumulate.
// Throughput: one item at a time; results leave one per cycle while rsp_tready is high.
// Reset: synchronous, active high; clears control and the registers (terms 0, outputs 1,
//   dims 4). Table contents are not cleared.
`default_nettype none
module multivariate_polynomial_eval_grad (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // term_index, output_index, exp_0..exp_3, coeff_value, point_0..point_3, zero fill
   input  wire logic [183:0] req_tdata,
   // func
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // response_value, grad_0, grad_1, grad_2, grad_3
   output logic [159:0]      rsp_tdata,
   // response_index, saturated
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [6:0]   csr_wdata
);

   localparam int QW = mpev_pkg::QW;
   localparam int ND = mpev_pkg::NDIM;

   logic [6:0] terms_ff;
   logic [2:0] outs_ff;
   logic [2:0] dims_ff;
   logic [6:0] nt_ff, nt_in;
   logic [2:0] no_ff, no_in;
   logic [2:0] nd_ff, nd_in;

   mpev_pkg::state_type state_ff, state_in;
   logic [6:0] term_ff, term_in;
   logic [2:0] step_ff, step_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] emit_ff, emit_in;
   logic       iss_vld_ff;
   logic [1:0] iss_sel_ff;
   logic       mul_vld_ff;
   logic [1:0] mul_sel_ff;
   logic       issue;
   logic       rsp_load;
   logic       req_xfer;
   logic       eval_go;

   logic                rsp_tvalid_ff;
   logic [159:0]        rsp_tdata_ff;
   logic [2:0]          rsp_tuser_ff;
   logic                rsp_tlast_ff;

   logic signed [QW-1:0] x_ff [ND];
   mpev_pkg::ctl_type    ctl;
   mpev_pkg::res_type    res;

   logic [11:0]            exp_rd;
   logic [QW-1:0]          coeff_rd;
   logic signed [QW-1:0]   pow_out [ND];
   logic signed [QW-1:0]   pow_sel;
   logic signed [mpev_pkg::ACC_W-1:0] lane_acc [ND];
   logic [ND-1:0]          lane_sat;

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == mpev_pkg::ST_IDLE);
   assign req_xfer = req_tvalid && req_tready;
   assign eval_go = req_xfer && req_tuser == mpev_pkg::FUNC_EVAL;

   always_ff @(posedge clock) begin
      if (reset) begin
         terms_ff <= 7'd0;
         outs_ff  <= 3'd1;
         dims_ff  <= 3'd4;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mpev_pkg::CSR_TERMS: terms_ff <= csr_wdata;
            mpev_pkg::CSR_OUTS:  outs_ff  <= csr_wdata[2:0];
            mpev_pkg::CSR_DIMS:  dims_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      nt_in = (terms_ff > 7'(mpev_pkg::NTERM)) ? 7'(mpev_pkg::NTERM) : terms_ff;
      no_in = (outs_ff == '0) ? 3'd1 : (outs_ff > 3'(mpev_pkg::NOUT)) ? 3'(mpev_pkg::NOUT)
                                                                   : outs_ff;
      nd_in = (dims_ff == '0) ? 3'd1 : (dims_ff > 3'(ND)) ? 3'(ND) : dims_ff;
   end

   mpev_ram #(.WIDTH(12), .DEPTH(64)) u_exp_ram (
      .clock   (clock),
      .wr_en   (req_xfer && req_tuser == mpev_pkg::FUNC_LOAD_EXP),
      .wr_addr (req_tdata[5:0]),
      .wr_data (req_tdata[19:8]),
      .rd_addr (term_ff[5:0]),
      .rd_data (exp_rd)
   );

   mpev_ram #(.WIDTH(32), .DEPTH(256)) u_coeff_ram (
      .clock   (clock),
      .wr_en   (req_xfer && req_tuser == mpev_pkg::FUNC_LOAD_COEF),
      .wr_addr ({req_tdata[5:0], req_tdata[7:6]}),
      .wr_data (req_tdata[51:20]),
      .rd_addr ({term_ff[5:0], cnt_ff[1:0]}),
      .rd_data (coeff_rd)
   );

   always_ff @(posedge clock) begin
      if (eval_go) begin
         for (int j = 0; j < ND; j++) begin
            x_ff[j] <= req_tdata[52 + QW*j +: QW];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      emit_in  = emit_ff;
      issue    = 1'b0;
      rsp_load = 1'b0;
      ctl            = '0;
      ctl.pow_k      = step_ff;
      ctl.chain_dim  = step_ff[1:0];
      ctl.mul_en     = iss_vld_ff;
      ctl.acc_en     = mul_vld_ff;
      ctl.acc_sel    = mul_sel_ff;
      ctl.rd_sel     = emit_ff;
      unique case (state_ff)
         mpev_pkg::ST_IDLE: begin
            if (eval_go) begin
               ctl.clear = 1'b1;
               term_in   = '0;
               emit_in   = '0;
               state_in  = (nt_in == '0) ? mpev_pkg::ST_EMIT : mpev_pkg::ST_FETCH;
            end
         end
         mpev_pkg::ST_FETCH: state_in = mpev_pkg::ST_LOAD;
         mpev_pkg::ST_LOAD: begin
            ctl.load = 1'b1;
            step_in  = '0;
            state_in = mpev_pkg::ST_POW;
         end
         mpev_pkg::ST_POW: begin
            ctl.pow_step = 1'b1;
            step_in      = step_ff + 3'd1;
            if (step_ff == 3'(mpev_pkg::MAX_DEG - 1)) begin
               step_in  = '0;
               state_in = mpev_pkg::ST_DINIT;
            end
         end
         mpev_pkg::ST_DINIT: begin
            ctl.dinit = 1'b1;
            state_in  = mpev_pkg::ST_CHAIN;
         end
         mpev_pkg::ST_CHAIN: begin
            ctl.chain_step = 1'b1;
            step_in        = step_ff + 3'd1;
            if (step_ff == 3'(ND - 1)) begin
               cnt_in   = '0;
               state_in = mpev_pkg::ST_COEF;
            end
         end
         mpev_pkg::ST_COEF: begin
            if (cnt_ff != no_ff) begin
               issue  = 1'b1;
               cnt_in = cnt_ff + 3'd1;
            end else if (!iss_vld_ff) begin
               term_in  = term_ff + 7'd1;
               state_in = (term_ff + 7'd1 == nt_ff) ? mpev_pkg::ST_EMIT : mpev_pkg::ST_FETCH;
            end
         end
         mpev_pkg::ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               emit_in  = emit_ff + 2'd1;
               if ({1'b0, emit_ff} + 3'd1 == no_ff) begin
                  state_in = mpev_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = mpev_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mpev_pkg::ST_IDLE;
         term_ff    <= '0;
         step_ff    <= '0;
         cnt_ff     <= '0;
         emit_ff    <= '0;
         nt_ff      <= '0;
         no_ff      <= 3'd1;
         nd_ff      <= 3'd1;
         iss_vld_ff <= 1'b0;
         iss_sel_ff <= '0;
         mul_vld_ff <= 1'b0;
         mul_sel_ff <= '0;
      end else begin
         state_ff   <= state_in;
         term_ff    <= term_in;
         step_ff    <= step_in;
         cnt_ff     <= cnt_in;
         emit_ff    <= emit_in;
         iss_vld_ff <= issue;
         iss_sel_ff <= cnt_ff[1:0];
         mul_vld_ff <= iss_vld_ff;
         mul_sel_ff <= iss_sel_ff;
         if (eval_go) begin
            nt_ff <= nt_in;
            no_ff <= no_in;
            nd_ff <= nd_in;
         end
      end
   end

   assign pow_sel = pow_out[step_ff[1:0]];

   for (genvar j = 0; j < ND; j++) begin : g_lane
      mpev_lane #(.LANE(j)) u_lane (
         .clock   (clock),
         .ctl     (ctl),
         .x       (x_ff[j]),
         .e_in    ((3'(j) < nd_ff) ? exp_rd[3*j +: 3] : 3'd0),
         .pow_sel (pow_sel),
         .coeff   (coeff_rd),
         .pow_out (pow_out[j]),
         .acc_out (lane_acc[j]),
         .sat_out (lane_sat[j])
      );
   end

   mpev_merge u_merge (
      .clock    (clock),
      .ctl      (ctl),
      .pow_sel  (pow_sel),
      .coeff    (coeff_rd),
      .lane_acc (lane_acc),
      .lane_sat (lane_sat),
      .res      (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata_ff <= {res.grad[3], res.grad[2], res.grad[1], res.grad[0], res.value};
         rsp_tuser_ff <= {res.sat, emit_ff};
         rsp_tlast_ff <= ({1'b0, emit_ff} + 3'd1 == no_ff);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   a_term_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != mpev_pkg::ST_IDLE |-> term_ff <= nt_ff)
      else $error("term counter ran past terms in use");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == mpev_pkg::ST_COEF |-> cnt_ff <= no_ff)
      else $error("coefficient issue count ran past outputs in use");

   a_eval_starts: assert property (@(posedge clock) disable iff (reset)
      eval_go |=> state_ff != mpev_pkg::ST_IDLE)
      else $error("evaluate transfer did not start work");

   a_acc_follows: assert property (@(posedge clock) disable iff (reset)
      mul_vld_ff |-> $past(iss_vld_ff))
      else $error("accumulate without a coefficient read");
`endif

endmodule
`default_nettype wire
